### hw/rtl/ncs_pkg.sv
package ncs_pkg;

  localparam int MAX_KNOTS = 64;
  localparam int IW = $clog2(MAX_KNOTS);
  localparam int CW = $clog2(MAX_KNOTS + 1);

  typedef logic signed [47:0] q48_t;
  typedef logic signed [51:0] q52_t;

  localparam q48_t LIM48 = 48'sh7FFF_FFFF_FFFF;
  localparam q52_t LIM52 = 52'sh0_7FFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    ST_BUILT     = 3'd0,
    ST_FOUND     = 3'd1,
    ST_OUTSIDE   = 3'd2,
    ST_FEW       = 3'd3,
    ST_NOT_INC   = 3'd4,
    ST_NOT_BUILT = 3'd5
  } status_t;

  typedef enum logic [5:0] {
    OP_NONE, OP_LATCH, OP_LOAD, OP_WR_S, OP_RES_FEW, OP_RES_NINC, OP_BINIT, OP_RD,
    OP_P1, OP_IX1, OP_P2A, OP_P2B, OP_P2C, OP_P2D, OP_P2E, OP_P3I, OP_P3A, OP_P3B,
    OP_P3C, OP_P4A, OP_P4B, OP_P4C, OP_P4D, OP_BDONE, OP_RES_NB, OP_IX0, OP_INC,
    OP_DEC, OP_RES_OUT, OP_QA, OP_QB, OP_QC, OP_QD, OP_QE, OP_QF, OP_QG, OP_QH, OP_QI
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   mul_go;
    logic   div_go;
  } dp_cmd_t;

  typedef struct packed {
    logic cmd;
    logic last;
    logic ready;
    logic few;
    logic bad;
    logic pend;
    logic ix_zero;
    logic ix_last;
    logic ix_end;
    logic n_two;
    logic x_ge;
    logic x_le;
    logic mul_busy;
    logic div_busy;
  } dp_stat_t;

  typedef enum logic [5:0] {
    S_IDLE, S_DISPATCH, S_LOAD, S_LOAD2, S_LOAD3, S_LOADE, S_BCHK,
    S_P1_RD, S_P1_WR, S_P2_IX, S_P2_RD, S_P2_OPS, S_P2_B, S_P2_C, S_P2_D,
    S_P2_RD2, S_P2_WR, S_P3_INIT, S_P3_RD, S_P3_A, S_P3_B, S_P3_C,
    S_P4_A, S_P4_GO, S_P4_W, S_P4_B, S_P4_C, S_P4_D, S_BDONE,
    S_QRY, S_Q_RD0, S_Q_C0, S_Q_RD, S_Q_CMP, S_Q_RDS,
    S_QA, S_QB, S_QC, S_QD, S_QE, S_QF, S_QG, S_QH, S_QI,
    S_MGO, S_MW, S_DGO, S_DW
  } ctrl_state_t;

  function automatic q48_t sat48(input q52_t v);
    if (v > LIM52) return LIM48;
    else if (v < -LIM52) return -LIM48;
    else return v[47:0];
  endfunction

  function automatic logic signed [31:0] sat32(input q48_t v);
    if (v > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    else if (v < 48'shFFFF_8000_0000) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  function automatic logic [47:0] mag48(input q48_t v);
    return v[47] ? 48'(-v) : v;
  endfunction

endpackage

### hw/rtl/natural_cubic_spline_engine.sv
// channel  | ports                                   | beat
// ---------+-----------------------------------------+---------------------------
// in       | command x_value f_value last_knot       | start high while busy low
// out      | status value slope curvature            | strobe high, one cycle
//
// a plain knot load after the first runs one 64-step divide for its slope
// a build's work per knot is dominated by three 64-step divides
// a query searches the segments in order from the first, then evaluates the polynomial
// reset is synchronous and empties the knot set; no clearing pass
// results cannot be held off and are dropped if not taken in their cycle
module natural_cubic_spline_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               command,
  input  logic signed [31:0] x_value,
  input  logic signed [31:0] f_value,
  input  logic               last_knot,
  output logic               strobe,
  output logic [2:0]         status,
  output logic signed [31:0] value,
  output logic signed [31:0] slope,
  output logic signed [31:0] curvature
);
  import ncs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ncs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  ncs_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .command(command), .x_value(x_value), .f_value(f_value), .last_knot(last_knot),
    .strobe(strobe), .status(status), .value(value), .slope(slope),
    .curvature(curvature)
  );

endmodule

### hw/rtl/ncs_mul.sv
module ncs_mul (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  ncs_pkg::q48_t a,
  input  ncs_pkg::q48_t b,
  output logic          busy,
  output ncs_pkg::q48_t product
);
  import ncs_pkg::*;

  logic [47:0] ua;
  logic [47:0] ub;
  logic        neg;
  logic [1:0]  step;
  logic [95:0] acc;
  logic [15:0] digit;
  logic [63:0] pp;
  logic [95:0] sum;
  logic [79:0] r;
  logic [47:0] m;

  always_comb begin
    case (step)
      2'd0:    digit = ub[15:0];
      2'd1:    digit = ub[31:16];
      default: digit = ub[47:32];
    endcase
    pp  = ua * digit;
    sum = acc + ({32'b0, pp} << (16 * step));
    r   = sum[95:16];
    m   = (r > 80'(LIM48)) ? LIM48 : r[47:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (go) begin
      busy <= 1'b1;
    end else if (busy && step == 2'd2) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      ua   <= mag48(a);
      ub   <= mag48(b);
      neg  <= a[47] ^ b[47];
      acc  <= '0;
      step <= '0;
    end else if (busy) begin
      acc  <= sum;
      step <= step + 2'd1;
      if (step == 2'd2) begin
        product <= neg ? -q48_t'(m) : q48_t'(m);
      end
    end
  end

endmodule

### hw/rtl/ncs_div.sv
module ncs_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  ncs_pkg::q48_t a,
  input  ncs_pkg::q48_t b,
  input  logic          shift16,
  output logic          busy,
  output ncs_pkg::q48_t quotient
);
  import ncs_pkg::*;

  logic [47:0] ua_go;
  logic [47:0] ub_go;
  logic [47:0] ub;
  logic        neg;
  logic [47:0] rem;
  logic [63:0] dq;
  logic [5:0]  cnt;
  logic [48:0] trial;
  logic [48:0] diff;
  logic        qbit;
  logic [63:0] qfin;
  logic [47:0] qsat;
  logic        by3;
  logic [17:0] val3;
  logic [35:0] prod3;
  logic [15:0] q3;
  logic [17:0] rem3;
  logic [47:0] quo3;

  // shift16 low divides a by three, 16 bits a step by reciprocal multiply
  always_comb begin
    ua_go = (mag48(a) > 48'(LIM48)) ? 48'(LIM48) : mag48(a);
    ub_go = mag48(b);
    trial = {rem, dq[63]};
    diff  = trial - {1'b0, ub};
    qbit  = (trial >= {1'b0, ub});
    qfin  = {dq[62:0], qbit};
    qsat  = (qfin > 64'(LIM48)) ? LIM48 : qfin[47:0];
    val3  = {rem[1:0], dq[47:32]};
    prod3 = val3 * 18'h2AAAB;
    q3    = prod3[34:19];
    rem3  = val3 - ({2'b0, q3} + {1'b0, q3, 1'b0});
    quo3  = {dq[31:0], q3};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (go) begin
      busy <= !shift16 || (ub_go != '0);
    end else if (busy && (by3 ? (cnt == 6'd2) : (cnt == 6'd63))) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      by3 <= !shift16;
      ub  <= ub_go;
      neg <= shift16 ? (a[47] ^ b[47]) : a[47];
      rem <= '0;
      cnt <= '0;
      dq  <= shift16 ? {ua_go, 16'b0} : {16'b0, ua_go};
      if (shift16 && ub_go == '0) begin
        quotient <= '0;
      end
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (by3) begin
        rem <= {46'b0, rem3[1:0]};
        dq  <= {16'b0, dq[31:0], q3};
        if (cnt == 6'd2) begin
          quotient <= neg ? -q48_t'(quo3) : q48_t'(quo3);
        end
      end else begin
        rem <= qbit ? diff[47:0] : trial[47:0];
        dq  <= qfin;
        if (cnt == 6'd63) begin
          quotient <= neg ? -q48_t'(qsat) : q48_t'(qsat);
        end
      end
    end
  end

endmodule

### hw/rtl/ncs_dp.sv
module ncs_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  ncs_pkg::dp_cmd_t        cmd,
  output ncs_pkg::dp_stat_t       stat,
  input  logic                    command,
  input  logic signed [31:0]      x_value,
  input  logic signed [31:0]      f_value,
  input  logic                    last_knot,
  output logic                    strobe,
  output logic [2:0]              status,
  output logic signed [31:0]      value,
  output logic signed [31:0]      slope,
  output logic signed [31:0]      curvature
);
  import ncs_pkg::*;

  logic signed [31:0] xm [MAX_KNOTS];
  logic signed [31:0] fm [MAX_KNOTS];
  logic [31:0]        hm [MAX_KNOTS];
  q48_t               sm [MAX_KNOTS];
  q48_t               dgm [MAX_KNOTS];
  q48_t               rhm [MAX_KNOTS];
  q48_t               bm [MAX_KNOTS];
  q48_t               cm [MAX_KNOTS];
  q48_t               dm [MAX_KNOTS];

  logic               cmd_q;
  logic               last_q;
  logic signed [31:0] xin;
  logic signed [31:0] fin;
  logic [CW-1:0]      count;
  logic               ready;
  logic               bad;
  logic               pend;
  logic signed [31:0] lastx;
  logic signed [31:0] lastf;
  logic [IW-1:0]      wix;
  logic [IW-1:0]      ix;
  logic [IW-1:0]      n;

  logic signed [31:0] x_rd;
  logic signed [31:0] f_rd;
  logic [31:0]        h_rd;
  q48_t               s_rd;
  q48_t               dg_rd;
  q48_t               rh_rd;
  q48_t               b_rd;
  q48_t               c_rd;
  q48_t               d_rd;

  logic [31:0] hp;
  q48_t        sp;
  q48_t        rp;
  q48_t        dp;
  q48_t        cn;
  q48_t        ci;
  q48_t        m;
  q48_t        tmp1;
  q48_t        tmp2;
  q48_t        t;
  q48_t        t2;
  q48_t        t3;
  q48_t        v;
  q48_t        sl;

  q48_t ma;
  q48_t mb;
  q48_t da;
  q48_t db;
  logic dsh;
  logic mul_busy;
  logic div_busy;
  q48_t mres;
  q48_t dres;

  logic [CW-1:0]      eff;
  logic               store;
  logic signed [32:0] xd;
  logic signed [32:0] fd;
  logic signed [32:0] td;
  logic [32:0]        hsum;
  q48_t               sdiff;
  q48_t               hp48;
  q48_t               h48;

  ncs_mul u_mul (
    .clk(clk), .rst(rst), .go(cmd.mul_go), .a(ma), .b(mb),
    .busy(mul_busy), .product(mres)
  );

  ncs_div u_div (
    .clk(clk), .rst(rst), .go(cmd.div_go), .a(da), .b(db), .shift16(dsh),
    .busy(div_busy), .quotient(dres)
  );

  always_comb begin
    eff   = ready ? '0 : count;
    store = (eff < CW'(MAX_KNOTS));
    xd    = 33'(xin) - 33'(lastx);
    fd    = 33'(fin) - 33'(lastf);
    td    = 33'(xin) - 33'(x_rd);
    hsum  = {1'b0, hp} + {1'b0, h_rd};
    sdiff = sat48(q52_t'(s_rd) - q52_t'(sp));
    hp48  = q48_t'({16'b0, hp});
    h48   = q48_t'({16'b0, h_rd});

    stat.cmd      = cmd_q;
    stat.last     = last_q;
    stat.ready    = ready;
    stat.few      = (count < CW'(3));
    stat.bad      = bad;
    stat.pend     = pend;
    stat.ix_zero  = (ix == '0);
    stat.ix_last  = (ix == n - 1'b1);
    stat.ix_end   = (ix == n);
    stat.n_two    = (n == IW'(2));
    stat.x_ge     = (xin >= x_rd);
    stat.x_le     = (xin <= x_rd);
    stat.mul_busy = mul_busy;
    stat.div_busy = div_busy;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      ready  <= 1'b0;
      bad    <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (cmd.op)
        OP_LOAD: begin
          ready <= 1'b0;
          if (ready) begin
            bad <= 1'b0;
          end
          if (store) begin
            count <= eff + 1'b1;
            if (eff != '0 && xin <= lastx) begin
              bad <= 1'b1;
            end
          end else begin
            count <= eff;
          end
        end
        OP_RES_FEW, OP_RES_NINC: begin
          count  <= '0;
          bad    <= 1'b0;
          strobe <= 1'b1;
        end
        OP_BDONE: begin
          ready  <= 1'b1;
          strobe <= 1'b1;
        end
        OP_RES_NB, OP_RES_OUT, OP_QI: begin
          strobe <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers and stores
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        cmd_q  <= command;
        last_q <= last_knot;
        xin    <= x_value;
        fin    <= f_value;
      end
      OP_LOAD: begin
        pend <= store && (eff != '0);
        if (store) begin
          xm[eff[IW-1:0]] <= xin;
          fm[eff[IW-1:0]] <= fin;
          lastx <= xin;
          lastf <= fin;
          wix   <= IW'(eff - 1'b1);
          da    <= q48_t'(fd);
          db    <= q48_t'(xd);
          dsh   <= 1'b1;
          if (eff != '0) begin
            hm[IW'(eff - 1'b1)] <= xd[31:0];
          end
        end
      end
      OP_WR_S: begin
        sm[wix] <= dres;
      end
      OP_BINIT: begin
        n  <= IW'(count - 1'b1);
        ix <= '0;
      end
      OP_RD: begin
        x_rd  <= xm[ix];
        f_rd  <= fm[ix];
        h_rd  <= hm[ix];
        s_rd  <= sm[ix];
        dg_rd <= dgm[ix];
        rh_rd <= rhm[ix];
        b_rd  <= bm[ix];
        c_rd  <= cm[ix];
        d_rd  <= dm[ix];
      end
      OP_P1: begin
        if (ix != '0) begin
          dgm[ix] <= q48_t'({14'b0, hsum, 1'b0});
          rhm[ix] <= sat48(q52_t'(sdiff) + (q52_t'(sdiff) <<< 1));
        end
        hp <= h_rd;
        sp <= s_rd;
        ix <= ix + 1'b1;
      end
      OP_IX1: begin
        ix <= IW'(1);
      end
      OP_P2A: begin
        da  <= h48;
        db  <= dg_rd;
        dsh <= 1'b1;
        hp  <= h_rd;
        rp  <= rh_rd;
      end
      OP_P2B: begin
        m  <= dres;
        ma <= dres;
        mb <= hp48;
      end
      OP_P2C: begin
        tmp1 <= mres;
        ma   <= m;
        mb   <= rp;
      end
      OP_P2D: begin
        tmp2 <= mres;
        ix   <= ix + 1'b1;
      end
      OP_P2E: begin
        dgm[ix] <= sat48(q52_t'(dg_rd) - q52_t'(tmp1));
        rhm[ix] <= sat48(q52_t'(rh_rd) - q52_t'(tmp2));
      end
      OP_P3I: begin
        ix <= n - 1'b1;
        cn <= '0;
      end
      OP_P3A: begin
        hp <= h_rd;
        sp <= s_rd;
        rp <= rh_rd;
        dp <= dg_rd;
        ci <= '0;
        ma <= cn;
        mb <= h48;
      end
      OP_P3B: begin
        da  <= sat48(q52_t'(rp) - q52_t'(mres));
        db  <= dp;
        dsh <= 1'b1;
      end
      OP_P3C: begin
        ci <= dres;
      end
      OP_P4A: begin
        ma  <= sat48(q52_t'(cn) + (q52_t'(ci) <<< 1));
        mb  <= hp48;
        da  <= sat48(q52_t'(cn) - q52_t'(ci));
        db  <= hp48;
        dsh <= 1'b1;
      end
      OP_P4B: begin
        tmp1 <= mres;
        da   <= dres;
        db   <= q48_t'(3);
        dsh  <= 1'b0;
      end
      OP_P4C: begin
        dm[ix] <= dres;
        da     <= tmp1;
        db     <= q48_t'(3);
        dsh    <= 1'b0;
      end
      OP_P4D: begin
        bm[ix] <= sat48(q52_t'(sp) - q52_t'(dres));
        cm[ix] <= ci;
        cn     <= ci;
        ix     <= ix - 1'b1;
      end
      OP_IX0: begin
        ix <= '0;
      end
      OP_INC: begin
        ix <= ix + 1'b1;
      end
      OP_DEC: begin
        ix <= ix - 1'b1;
      end
      OP_QA: begin
        t  <= q48_t'(td);
        ma <= q48_t'(td);
        mb <= q48_t'(td);
        v  <= q48_t'(f_rd);
      end
      OP_QB: begin
        t2 <= mres;
        ma <= mres;
        mb <= t;
      end
      OP_QC: begin
        t3 <= mres;
        ma <= b_rd;
        mb <= t;
      end
      OP_QD: begin
        v  <= sat48(q52_t'(v) + q52_t'(mres));
        ma <= c_rd;
        mb <= t2;
      end
      OP_QE: begin
        v  <= sat48(q52_t'(v) + q52_t'(mres));
        ma <= d_rd;
        mb <= t3;
      end
      OP_QF: begin
        v  <= sat48(q52_t'(v) + q52_t'(mres));
        ma <= c_rd;
        mb <= t;
      end
      OP_QG: begin
        sl <= sat48(q52_t'(b_rd) + q52_t'(sat48(q52_t'(mres) <<< 1)));
        ma <= d_rd;
        mb <= t2;
      end
      OP_QH: begin
        sl <= sat48(q52_t'(sl) + q52_t'(sat48(q52_t'(mres) * q52_t'(3))));
        ma <= d_rd;
        mb <= t;
      end
      default: begin
      end
    endcase
  end

  // result beat
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_RES_FEW, OP_RES_NINC, OP_BDONE, OP_RES_NB, OP_RES_OUT: begin
        value     <= '0;
        slope     <= '0;
        curvature <= '0;
        case (cmd.op)
          OP_RES_FEW:  status <= ST_FEW;
          OP_RES_NINC: status <= ST_NOT_INC;
          OP_BDONE:    status <= ST_BUILT;
          OP_RES_NB:   status <= ST_NOT_BUILT;
          default:     status <= ST_OUTSIDE;
        endcase
      end
      OP_QI: begin
        status    <= ST_FOUND;
        value     <= sat32(v);
        slope     <= sat32(sl);
        curvature <= sat32(sat48(q52_t'(sat48(q52_t'(c_rd) <<< 1))
                     + q52_t'(sat48(q52_t'(mres) * q52_t'(6)))));
      end
      default: begin
      end
    endcase
  end

endmodule

### hw/rtl/ncs_ctrl.sv
module ncs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ncs_pkg::dp_stat_t  stat,
  output ncs_pkg::dp_cmd_t   cmd
);
  import ncs_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  ctrl_state_t ret;
  ctrl_state_t ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd.op     = OP_NONE;
    cmd.mul_go = 1'b0;
    cmd.div_go = 1'b0;
    busy       = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LATCH;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: state_next = stat.cmd ? S_QRY : S_LOAD;
      S_LOAD: begin
        cmd.op     = OP_LOAD;
        state_next = S_LOAD2;
      end
      S_LOAD2: begin
        if (stat.pend) begin
          state_next = S_DGO;
          ret_next   = S_LOAD3;
        end else begin
          state_next = S_LOADE;
        end
      end
      S_LOAD3: begin
        cmd.op     = OP_WR_S;
        state_next = S_LOADE;
      end
      S_LOADE: state_next = stat.last ? S_BCHK : S_IDLE;
      S_BCHK: begin
        if (stat.few) begin
          cmd.op     = OP_RES_FEW;
          state_next = S_IDLE;
        end else if (stat.bad) begin
          cmd.op     = OP_RES_NINC;
          state_next = S_IDLE;
        end else begin
          cmd.op     = OP_BINIT;
          state_next = S_P1_RD;
        end
      end
      S_P1_RD: begin
        cmd.op     = OP_RD;
        state_next = S_P1_WR;
      end
      S_P1_WR: begin
        cmd.op = OP_P1;
        if (!stat.ix_last) state_next = S_P1_RD;
        else if (stat.n_two) state_next = S_P3_INIT;
        else state_next = S_P2_IX;
      end
      S_P2_IX: begin
        cmd.op     = OP_IX1;
        state_next = S_P2_RD;
      end
      S_P2_RD: begin
        cmd.op     = OP_RD;
        state_next = S_P2_OPS;
      end
      S_P2_OPS: begin
        cmd.op     = OP_P2A;
        state_next = S_DGO;
        ret_next   = S_P2_B;
      end
      S_P2_B: begin
        cmd.op     = OP_P2B;
        state_next = S_MGO;
        ret_next   = S_P2_C;
      end
      S_P2_C: begin
        cmd.op     = OP_P2C;
        state_next = S_MGO;
        ret_next   = S_P2_D;
      end
      S_P2_D: begin
        cmd.op     = OP_P2D;
        state_next = S_P2_RD2;
      end
      S_P2_RD2: begin
        cmd.op     = OP_RD;
        state_next = S_P2_WR;
      end
      S_P2_WR: begin
        cmd.op     = OP_P2E;
        state_next = stat.ix_last ? S_P3_INIT : S_P2_RD;
      end
      S_P3_INIT: begin
        cmd.op     = OP_P3I;
        state_next = S_P3_RD;
      end
      S_P3_RD: begin
        cmd.op     = OP_RD;
        state_next = S_P3_A;
      end
      S_P3_A: begin
        cmd.op = OP_P3A;
        if (stat.ix_zero) begin
          state_next = S_P4_A;
        end else begin
          state_next = S_MGO;
          ret_next   = S_P3_B;
        end
      end
      S_P3_B: begin
        cmd.op     = OP_P3B;
        state_next = S_DGO;
        ret_next   = S_P3_C;
      end
      S_P3_C: begin
        cmd.op     = OP_P3C;
        state_next = S_P4_A;
      end
      S_P4_A: begin
        cmd.op     = OP_P4A;
        state_next = S_P4_GO;
      end
      S_P4_GO: begin
        cmd.mul_go = 1'b1;
        cmd.div_go = 1'b1;
        state_next = S_P4_W;
      end
      S_P4_W: begin
        if (!stat.mul_busy && !stat.div_busy) state_next = S_P4_B;
      end
      S_P4_B: begin
        cmd.op     = OP_P4B;
        state_next = S_DGO;
        ret_next   = S_P4_C;
      end
      S_P4_C: begin
        cmd.op     = OP_P4C;
        state_next = S_DGO;
        ret_next   = S_P4_D;
      end
      S_P4_D: begin
        cmd.op     = OP_P4D;
        state_next = stat.ix_zero ? S_BDONE : S_P3_RD;
      end
      S_BDONE: begin
        cmd.op     = OP_BDONE;
        state_next = S_IDLE;
      end
      S_QRY: begin
        if (!stat.ready) begin
          cmd.op     = OP_RES_NB;
          state_next = S_IDLE;
        end else begin
          cmd.op     = OP_IX0;
          state_next = S_Q_RD0;
        end
      end
      S_Q_RD0: begin
        cmd.op     = OP_RD;
        state_next = S_Q_C0;
      end
      S_Q_C0: begin
        if (!stat.x_ge) begin
          cmd.op     = OP_RES_OUT;
          state_next = S_IDLE;
        end else begin
          cmd.op     = OP_INC;
          state_next = S_Q_RD;
        end
      end
      S_Q_RD: begin
        cmd.op     = OP_RD;
        state_next = S_Q_CMP;
      end
      S_Q_CMP: begin
        if (stat.x_le) begin
          cmd.op     = OP_DEC;
          state_next = S_Q_RDS;
        end else if (stat.ix_end) begin
          cmd.op     = OP_RES_OUT;
          state_next = S_IDLE;
        end else begin
          cmd.op     = OP_INC;
          state_next = S_Q_RD;
        end
      end
      S_Q_RDS: begin
        cmd.op     = OP_RD;
        state_next = S_QA;
      end
      S_QA: begin
        cmd.op     = OP_QA;
        state_next = S_MGO;
        ret_next   = S_QB;
      end
      S_QB: begin
        cmd.op     = OP_QB;
        state_next = S_MGO;
        ret_next   = S_QC;
      end
      S_QC: begin
        cmd.op     = OP_QC;
        state_next = S_MGO;
        ret_next   = S_QD;
      end
      S_QD: begin
        cmd.op     = OP_QD;
        state_next = S_MGO;
        ret_next   = S_QE;
      end
      S_QE: begin
        cmd.op     = OP_QE;
        state_next = S_MGO;
        ret_next   = S_QF;
      end
      S_QF: begin
        cmd.op     = OP_QF;
        state_next = S_MGO;
        ret_next   = S_QG;
      end
      S_QG: begin
        cmd.op     = OP_QG;
        state_next = S_MGO;
        ret_next   = S_QH;
      end
      S_QH: begin
        cmd.op     = OP_QH;
        state_next = S_MGO;
        ret_next   = S_QI;
      end
      S_QI: begin
        cmd.op     = OP_QI;
        state_next = S_IDLE;
      end
      S_MGO: begin
        cmd.mul_go = 1'b1;
        state_next = S_MW;
      end
      S_MW: begin
        if (!stat.mul_busy) state_next = ret;
      end
      S_DGO: begin
        cmd.div_go = 1'b1;
        state_next = S_DW;
      end
      S_DW: begin
        if (!stat.div_busy) state_next = ret;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
